// ===== design/qpi_pkg.sv =====
// Shared types, codes and arithmetic helpers for the quadrature point interpolator.
`timescale 1ns / 1ps
package qpi_pkg;

    localparam int DEF_MAX_DOFS       = 8;
    localparam int DEF_MAX_POINTS     = 8;
    localparam int DEF_MAX_COMPONENTS = 3;
    localparam int QFIFO_DEPTH        = 2;

    localparam logic [2:0] OP_BASIS    = 3'd0;
    localparam logic [2:0] OP_GRADIENT = 3'd1;
    localparam logic [2:0] OP_DOF_VAL  = 3'd2;
    localparam logic [2:0] OP_DOF_DET  = 3'd3;
    localparam logic [2:0] OP_JACOBIAN = 3'd4;
    localparam logic [2:0] OP_EVALUATE = 3'd5;

    localparam logic [2:0] CFG_NUM_DOFS   = 3'd0;
    localparam logic [2:0] CFG_NUM_POINTS = 3'd1;
    localparam logic [2:0] CFG_NUM_COMP   = 3'd2;
    localparam logic [2:0] CFG_EVAL_MASK  = 3'd3;
    localparam logic [2:0] CFG_INTEGRAL   = 3'd4;
    localparam logic [2:0] CFG_ORDER      = 3'd5;

    localparam logic signed [63:0] TERM_LIM = 64'sd1 <<< 56;
    localparam logic signed [63:0] PHYS_LIM = 64'sd1 <<< 46;
    localparam logic signed [63:0] I32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN  = -64'sd2147483648;

    typedef enum logic [2:0] {
        KIND_BASIS,
        KIND_GRAD,
        KIND_DOFVAL,
        KIND_DET,
        KIND_JAC,
        KIND_EVAL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [1:0]         comp;
        logic signed [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic [3:0] num_dofs;
        logic [3:0] num_points;
        logic [1:0] num_components;
        logic [3:0] eval_mask;
        logic       integral_mode;
        logic       output_order;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         point_index;
        logic [1:0]         component;
        logic signed [31:0] value;
        logic signed [31:0] derivative;
        logic signed [31:0] determinant;
        logic               div_fault;
        logic               last;
    } res_t;

    typedef struct packed {
        logic signed [63:0] v;
        logic               f;
    } clamp_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic               f;
    } sat_t;

    function automatic clamp_t clamp64(input logic signed [63:0] v,
                                       input logic signed [63:0] lim);
        clamp_t r;
        r.v = v;
        r.f = 1'b0;
        if (v > lim) begin
            r.v = lim;
            r.f = 1'b1;
        end else if (v < -lim) begin
            r.v = -lim;
            r.f = 1'b1;
        end
        return r;
    endfunction

    // An input equal to the most negative code lands one above it, still flagged.
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        r.v = v[31:0];
        r.f = 1'b0;
        if (v > I32_MAX) begin
            r.v = I32_MAX[31:0];
            r.f = 1'b1;
        end else if (v < I32_MIN) begin
            r.v = I32_MIN[31:0];
            r.f = 1'b1;
        end else if (v == I32_MIN) begin
            r.v = I32_MIN[31:0] + 32'sd1;
            r.f = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] q16_trunc(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p[63] ? p + 64'sd65535 : p;
        return t >>> 16;
    endfunction

endpackage

// ===== design/quadrature_point_interpolator.sv =====
// Top level of the quadrature point interpolator: ports, config registers, front and back.
// Usage:
//   s_ channel carries requests: s_tuser is the opcode, s_tdata holds the indices and data.
//   Load requests fill basis, gradient, dof value, determinant and jacobian stores.
//   An evaluate request emits nq*nc results on the m_ channel, m_tlast on the final one.
//   cfg_ channel writes the six configuration registers; cfg_ready is always high.
// Operation:
//   A load is retired once it reaches the sequencer.
//   Each result is formed from up to two dot products over nd DOFs; in integral mode
//   every term is divided by its determinant, and a physical derivative adds one more
//   division by the point's jacobian.
//   The shared bit-serial divider and the single 32x32 multiplier serve all of these.
//   A two-entry request queue lets new requests in while an evaluate runs.
// Reset:
//   aresetn low clears the queue, sequencer and output valid, and restores register
//   defaults; the stores are undefined until written.
// Stall:
//   A result waits in the output register; the sequencer computes the next one and
//   holds it until m_tready frees the register.
`timescale 1ns / 1ps
module quadrature_point_interpolator
    import qpi_pkg::*;
#(
    parameter int MAX_DOFS       = DEF_MAX_DOFS,
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // row_index, col_index, comp_index, data_word
    input  logic [2:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // point_index, component, value, derivative, determinant
    output logic [0:0]   m_tuser,   // div_fault
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [3:0]   cfg_data
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_valid;
    cmd_t f_cmd, q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_dofs       <= 4'd2;
            cfg_reg.num_points     <= 4'd2;
            cfg_reg.num_components <= 2'd1;
            cfg_reg.eval_mask      <= 4'd1;
            cfg_reg.integral_mode  <= 1'b0;
            cfg_reg.output_order   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NUM_DOFS:   cfg_reg.num_dofs       <= cfg_data;
                CFG_NUM_POINTS: cfg_reg.num_points     <= cfg_data;
                CFG_NUM_COMP:   cfg_reg.num_components <= cfg_data[1:0];
                CFG_EVAL_MASK:  cfg_reg.eval_mask      <= cfg_data;
                CFG_INTEGRAL:   cfg_reg.integral_mode  <= cfg_data[0];
                CFG_ORDER:      cfg_reg.output_order   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    qpi_front #(
        .MAX_DOFS       (MAX_DOFS),
        .MAX_POINTS     (MAX_POINTS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (f_cmd)
    );

    qpi_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_cmd   (f_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    qpi_back #(
        .MAX_DOFS       (MAX_DOFS),
        .MAX_POINTS     (MAX_POINTS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {3'b000, res.determinant, res.derivative, res.value,
                      res.component, res.point_index};
    assign m_tuser = res.div_fault;
    assign m_tlast = res.last;

endmodule

// ===== design/qpi_div.sv =====
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module qpi_div
    import qpi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [31:0]        dvs_reg;
    logic               neg_reg;
    logic signed [63:0] res_reg;

    logic [32:0] rem_sh;
    logic        take;
    logic [31:0] rem_next;
    logic [63:0] quo_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[63]};
        take     = rem_sh >= {1'b0, dvs_reg};
        rem_next = take ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
        quo_next = {quo_reg[62:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
                rem_reg  <= '0;
                quo_reg  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
                dvs_reg  <= divisor[31] ? 32'(-divisor) : 32'(divisor);
                neg_reg  <= dividend[63] ^ divisor[31];
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= neg_reg ? -$signed(quo_next) : $signed(quo_next);
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// ===== design/qpi_fifo.sv =====
// Short request queue between the front decoder and the back sequencer.
`timescale 1ns / 1ps
module qpi_fifo
    import qpi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wr_cmd,
    input  logic pop,
    output logic full,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    localparam int AW = (QFIFO_DEPTH > 1) ? $clog2(QFIFO_DEPTH) : 1;
    localparam int CW = $clog2(QFIFO_DEPTH + 1);

    cmd_t          mem_reg [QFIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QFIFO_DEPTH - 1) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QFIFO_DEPTH - 1) ? '0 : rd_ptr_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    assign full     = int'(cnt_reg) == QFIFO_DEPTH;
    assign rd_valid = cnt_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];

endmodule

// ===== design/qpi_front.sv =====
// Front decoder: accept input requests, classify them and drop the ones that do nothing.
`timescale 1ns / 1ps
module qpi_front
    import qpi_pkg::*;
#(
    parameter int MAX_DOFS       = DEF_MAX_DOFS,
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        q_full,
    output logic        push,
    output cmd_t        cmd
);

    logic keep;

    always_comb begin
        cmd.row  = s_tdata[2:0];
        cmd.col  = s_tdata[5:3];
        cmd.comp = s_tdata[7:6];
        cmd.data = s_tdata[39:8];
        cmd.kind = KIND_EVAL;
        keep     = 1'b0;
        unique case (s_tuser)
            OP_BASIS: begin
                cmd.kind = KIND_BASIS;
                keep = int'(cmd.row) < MAX_POINTS && int'(cmd.col) < MAX_DOFS;
            end
            OP_GRADIENT: begin
                cmd.kind = KIND_GRAD;
                keep = int'(cmd.row) < MAX_POINTS && int'(cmd.col) < MAX_DOFS;
            end
            OP_DOF_VAL: begin
                cmd.kind = KIND_DOFVAL;
                keep = int'(cmd.row) < MAX_DOFS && int'(cmd.comp) < MAX_COMPONENTS;
            end
            OP_DOF_DET: begin
                cmd.kind = KIND_DET;
                keep = int'(cmd.row) < MAX_DOFS;
            end
            OP_JACOBIAN: begin
                cmd.kind = KIND_JAC;
                keep = int'(cmd.row) < MAX_POINTS;
            end
            OP_EVALUATE: begin
                cmd.kind = KIND_EVAL;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && keep;

endmodule

// ===== design/qpi_back.sv =====
// Back sequencer: table stores, multiply-accumulate walk and result register.
`timescale 1ns / 1ps
module qpi_back
    import qpi_pkg::*;
#(
    parameter int MAX_DOFS       = DEF_MAX_DOFS,
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    localparam int BDEPTH = MAX_POINTS * MAX_DOFS;
    localparam int VDEPTH = MAX_DOFS * MAX_COMPONENTS;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int DIW    = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
    localparam int PIW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DCW    = $clog2(MAX_DOFS + 1);
    localparam int PCW    = $clog2(MAX_POINTS + 1);
    localparam int CCW    = $clog2(MAX_COMPONENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RES, S_RD, S_MUL, S_DIVS, S_DIVW, S_ACC,
        S_NXT, S_PHYS, S_PDIVW, S_DSAT, S_EMIT
    } state_t;

    state_t state_reg;

    logic signed [31:0] basis_mem [BDEPTH];
    logic signed [31:0] grad_mem  [BDEPTH];
    logic signed [31:0] dval_mem  [VDEPTH];
    logic signed [31:0] det_mem   [MAX_DOFS];
    logic signed [31:0] jac_mem   [MAX_POINTS];

    logic signed [31:0] basis_rd, grad_rd, dval_rd, det_rd, jac_rd;

    logic [DCW-1:0] nd_reg, d_reg;
    logic [PCW-1:0] nq_reg, q_reg;
    logic [CCW-1:0] nc_reg, c_reg;
    logic integ_reg, val_en_reg, der_en_reg, phys_reg, det_en_reg, grad_en_reg, ord_reg;
    logic sel_reg;
    logic signed [63:0] p_reg, term_reg, acc_reg, s_reg;
    logic forced_reg, forced_neg_reg, dflt_reg, gflt_reg, fault_reg;
    logic signed [31:0] val_res_reg, der_res_reg;
    logic m_valid_reg;
    res_t m_res_reg;

    logic [BAW-1:0] b_raddr, b_waddr;
    logic [VAW-1:0] v_raddr, v_waddr;
    logic [DIW-1:0] d_idx;
    logic [PIW-1:0] q_idx;
    logic           out_free, is_last, emit_go;
    logic           div_start, div_busy, div_done;
    logic signed [63:0] div_dividend, div_quo, dot_val;
    logic signed [31:0] div_divisor;
    clamp_t term_c, phys_c;
    sat_t   dot_sat, der_sat;

    function automatic int clamp_cfg(input int v, input int hi);
        int r;
        r = v;
        if (v == 0) r = 1;
        else if (v > hi) r = hi;
        return r;
    endfunction

    assign d_idx   = d_reg[DIW-1:0];
    assign q_idx   = q_reg[PIW-1:0];
    assign b_raddr = BAW'(int'(q_reg) * MAX_DOFS + int'(d_reg));
    assign v_raddr = VAW'(int'(d_reg) * MAX_COMPONENTS + int'(c_reg));
    assign b_waddr = BAW'(int'(q_cmd.row) * MAX_DOFS + int'(q_cmd.col));
    assign v_waddr = VAW'(int'(q_cmd.row) * MAX_COMPONENTS + int'(q_cmd.comp));
    assign q_pop   = state_reg == S_IDLE && q_valid;

    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.kind == KIND_BASIS)  basis_mem[b_waddr] <= q_cmd.data;
        if (q_pop && q_cmd.kind == KIND_GRAD)   grad_mem[b_waddr]  <= q_cmd.data;
        if (q_pop && q_cmd.kind == KIND_DOFVAL) dval_mem[v_waddr]  <= q_cmd.data;
        if (q_pop && q_cmd.kind == KIND_DET)    det_mem[DIW'(q_cmd.row)] <= q_cmd.data;
        if (q_pop && q_cmd.kind == KIND_JAC)    jac_mem[PIW'(q_cmd.row)] <= q_cmd.data;
        basis_rd <= basis_mem[b_raddr];
        grad_rd  <= grad_mem[b_raddr];
        dval_rd  <= dval_mem[v_raddr];
        det_rd   <= det_mem[d_idx];
        jac_rd   <= jac_mem[q_idx];
    end

    always_comb begin
        term_c   = clamp64(term_reg, TERM_LIM);
        phys_c   = clamp64(s_reg, PHYS_LIM);
        dot_val  = forced_reg ? (forced_neg_reg ? I32_MIN : I32_MAX) : acc_reg;
        dot_sat  = sat32(dot_val);
        der_sat  = sat32(s_reg);
        out_free = !m_valid_reg || m_ready;
        emit_go  = state_reg == S_EMIT && out_free;
        is_last  = (q_reg + PCW'(1)) == nq_reg && (c_reg + CCW'(1)) == nc_reg;
        div_start = 1'b0;
        div_dividend = p_reg;
        div_divisor  = det_rd;
        if (state_reg == S_DIVS && integ_reg && det_rd != 32'sd0) begin
            div_start = 1'b1;
        end
        if (state_reg == S_PHYS && jac_rd != 32'sd0) begin
            div_start    = 1'b1;
            div_dividend = phys_c.v <<< 16;
            div_divisor  = jac_rd;
        end
    end

    qpi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !emit_go) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_cmd.kind == KIND_EVAL) begin
                        nd_reg      <= DCW'(clamp_cfg(int'(cfg.num_dofs), MAX_DOFS));
                        nq_reg      <= PCW'(clamp_cfg(int'(cfg.num_points), MAX_POINTS));
                        nc_reg      <= CCW'(clamp_cfg(int'(cfg.num_components), MAX_COMPONENTS));
                        integ_reg   <= cfg.integral_mode;
                        ord_reg     <= cfg.output_order;
                        val_en_reg  <= cfg.eval_mask[0];
                        phys_reg    <= cfg.eval_mask[2];
                        der_en_reg  <= cfg.eval_mask[1] | cfg.eval_mask[2];
                        det_en_reg  <= cfg.eval_mask[3] &&
                                       clamp_cfg(int'(cfg.num_components), MAX_COMPONENTS) == 1;
                        grad_en_reg <= cfg.eval_mask[1] | cfg.eval_mask[2] ||
                                       (cfg.eval_mask[3] &&
                                       clamp_cfg(int'(cfg.num_components), MAX_COMPONENTS) == 1);
                        q_reg       <= '0;
                        c_reg       <= '0;
                        state_reg   <= S_RES;
                    end
                end
                S_RES: begin
                    val_res_reg    <= '0;
                    der_res_reg    <= '0;
                    fault_reg      <= 1'b0;
                    d_reg          <= '0;
                    acc_reg        <= '0;
                    forced_reg     <= 1'b0;
                    forced_neg_reg <= 1'b0;
                    dflt_reg       <= 1'b0;
                    sel_reg        <= !val_en_reg;
                    state_reg      <= (val_en_reg || grad_en_reg) ? S_RD : S_EMIT;
                end
                S_RD: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    p_reg     <= (sel_reg ? grad_rd : basis_rd) * dval_rd;
                    state_reg <= S_DIVS;
                end
                S_DIVS: begin
                    if (!integ_reg) begin
                        term_reg  <= q16_trunc(p_reg);
                        state_reg <= S_ACC;
                    end else if (det_rd == 32'sd0) begin
                        if (!forced_reg) begin
                            forced_reg     <= 1'b1;
                            forced_neg_reg <= p_reg[63];
                        end
                        dflt_reg  <= 1'b1;
                        state_reg <= S_NXT;
                    end else begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        term_reg  <= div_quo;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    acc_reg   <= acc_reg + term_c.v;
                    dflt_reg  <= dflt_reg | term_c.f;
                    state_reg <= S_NXT;
                end
                S_NXT: begin
                    if ((d_reg + DCW'(1)) != nd_reg) begin
                        d_reg     <= d_reg + DCW'(1);
                        state_reg <= S_RD;
                    end else if (!sel_reg) begin
                        val_res_reg <= dot_sat.v;
                        fault_reg   <= dflt_reg | dot_sat.f;
                        if (grad_en_reg) begin
                            sel_reg        <= 1'b1;
                            d_reg          <= '0;
                            acc_reg        <= '0;
                            forced_reg     <= 1'b0;
                            forced_neg_reg <= 1'b0;
                            dflt_reg       <= 1'b0;
                            state_reg      <= S_RD;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end else begin
                        s_reg     <= dot_val;
                        gflt_reg  <= dflt_reg;
                        state_reg <= (phys_reg && !forced_reg) ? S_PHYS : S_DSAT;
                    end
                end
                S_PHYS: begin
                    if (jac_rd == 32'sd0) begin
                        s_reg     <= s_reg[63] ? I32_MIN : I32_MAX;
                        gflt_reg  <= 1'b1;
                        state_reg <= S_DSAT;
                    end else begin
                        gflt_reg  <= gflt_reg | phys_c.f;
                        state_reg <= S_PDIVW;
                    end
                end
                S_PDIVW: begin
                    if (div_done) begin
                        s_reg     <= div_quo;
                        state_reg <= S_DSAT;
                    end
                end
                S_DSAT: begin
                    der_res_reg <= der_sat.v;
                    fault_reg   <= fault_reg | gflt_reg | der_sat.f;
                    state_reg   <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg             <= 1'b1;
                        m_res_reg.point_index   <= 3'(q_reg);
                        m_res_reg.component     <= 2'(c_reg);
                        m_res_reg.value         <= val_res_reg;
                        m_res_reg.derivative    <= der_en_reg ? der_res_reg : 32'sd0;
                        m_res_reg.determinant   <= det_en_reg ? der_res_reg : 32'sd0;
                        m_res_reg.div_fault     <= fault_reg;
                        m_res_reg.last          <= is_last;
                        if (is_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_RES;
                            if (!ord_reg) begin
                                if ((c_reg + CCW'(1)) != nc_reg) begin
                                    c_reg <= c_reg + CCW'(1);
                                end else begin
                                    c_reg <= '0;
                                    q_reg <= q_reg + PCW'(1);
                                end
                            end else begin
                                if ((q_reg + PCW'(1)) != nq_reg) begin
                                    q_reg <= q_reg + PCW'(1);
                                end else begin
                                    q_reg <= '0;
                                    c_reg <= c_reg + CCW'(1);
                                end
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && !out_free) |=> $stable(m_res_reg))
        else $error("result overwritten while waiting");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && is_last) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after last result");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid && state_reg == S_IDLE)
        else $error("queue popped outside idle");

endmodule

// ===== tb/sv/quadrature_point_interpolator_test.sv =====
// Self-checking testbench for the quadrature point interpolator stream block.
`timescale 1ns / 1ps
module quadrature_point_interpolator_test;
    import qpi_pkg::*;

    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam longint TERM_BOUND = 64'sd1 <<< 56;
    localparam longint PHYS_BOUND = 64'sd1 <<< 46;
    localparam int NDOF = DEF_MAX_DOFS;
    localparam int NPT = DEF_MAX_POINTS;
    localparam int NCOMP = DEF_MAX_COMPONENTS;

    typedef struct {
        longint v;
        bit     forced;
        bit     fault;
    } dot_sum_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [3:0]   cfg_data = '0;

    quadrature_point_interpolator DUT (.*);

    always #4 aclk = ~aclk;

    logic signed [31:0] basis_tab [NPT*NDOF];
    logic signed [31:0] grad_tab [NPT*NDOF];
    logic signed [31:0] dof_val [NDOF*NCOMP];
    logic signed [31:0] dof_det [NDOF];
    logic signed [31:0] pt_jac [NPT];

    logic [3:0] r_dofs = 4'd2, r_points = 4'd2, r_mask = 4'd1;
    logic [1:0] r_comps = 2'd1;
    logic       r_integ = 1'b0, r_order = 1'b0;

    res_t pending_results [$];
    int   mismatches = 0;
    int   src_idle = 0, snk_idle = 0;
    res_t want, got;

    function automatic longint clamp_to(longint v, longint lim, inout bit f);
        if (v > lim) begin
            f = 1'b1;
            return lim;
        end
        if (v < -lim) begin
            f = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic longint fit_word(longint v, inout bit f);
        if (v > W_MAX) begin
            f = 1'b1;
            return W_MAX;
        end
        if (v < W_MIN) begin
            f = 1'b1;
            return W_MIN;
        end
        if (v == W_MIN) begin
            f = 1'b1;
            return W_MIN + 1;
        end
        return v;
    endfunction

    function automatic int cap_count(logic [3:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic dot_sum_t dof_dot(bit use_grad, int q, int c, int nd);
        dot_sum_t r;
        longint acc, p, dv;
        r = '{0, 1'b0, 1'b0};
        acc = 0;
        for (int d = 0; d < nd; d++) begin
            p = longint'(use_grad ? grad_tab[q*NDOF+d] : basis_tab[q*NDOF+d]) *
                longint'(dof_val[d*NCOMP+c]);
            dv = r_integ ? longint'(dof_det[d]) : 64'sd65536;
            if (dv == 0) begin
                if (!r.forced) begin
                    r.forced = 1'b1;
                    r.v = p < 0 ? W_MIN : W_MAX;
                end
                r.fault = 1'b1;
            end else begin
                acc += clamp_to(p / dv, TERM_BOUND, r.fault);
            end
        end
        if (!r.forced) r.v = acc;
        return r;
    endfunction

    task automatic predict_element();
        int nd, nq, nc, outer_n, inner_n, q, c;
        bit want_val, want_der, want_phys, want_det, fault, gf;
        longint val, der, s, jac;
        dot_sum_t ds;
        res_t r;
        nd = cap_count(r_dofs, NDOF);
        nq = cap_count(r_points, NPT);
        nc = cap_count({2'b00, r_comps}, NCOMP);
        want_val = r_mask[0];
        want_phys = r_mask[2];
        want_der = r_mask[1] | r_mask[2];
        want_det = r_mask[3] && nc == 1;
        outer_n = r_order ? nc : nq;
        inner_n = r_order ? nq : nc;
        for (int o = 0; o < outer_n; o++) begin
            for (int i = 0; i < inner_n; i++) begin
                q = r_order ? i : o;
                c = r_order ? o : i;
                val = 0;
                der = 0;
                fault = 1'b0;
                if (want_val) begin
                    ds = dof_dot(1'b0, q, c, nd);
                    fault = ds.fault;
                    val = fit_word(ds.v, fault);
                end
                if (want_der || want_det) begin
                    ds = dof_dot(1'b1, q, c, nd);
                    s = ds.v;
                    gf = ds.fault;
                    if (want_phys && !ds.forced) begin
                        jac = longint'(pt_jac[q]);
                        if (jac == 0) begin
                            s = s < 0 ? W_MIN : W_MAX;
                            gf = 1'b1;
                        end else begin
                            s = clamp_to(s, PHYS_BOUND, gf);
                            s = (s * 64'sd65536) / jac;
                        end
                    end
                    der = fit_word(s, gf);
                    fault = fault | gf;
                end
                r.point_index = q[2:0];
                r.component = c[1:0];
                r.value = val[31:0];
                r.derivative = want_der ? der[31:0] : 32'd0;
                r.determinant = want_det ? der[31:0] : 32'd0;
                r.div_fault = fault;
                r.last = (o + 1 == outer_n) && (i + 1 == inner_n);
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic apply_request(logic [2:0] op, logic [2:0] row, logic [2:0] col,
                                 logic [1:0] comp, logic [31:0] data);
        case (op)
            OP_BASIS:    basis_tab[row*NDOF+col] = data;
            OP_GRADIENT: grad_tab[row*NDOF+col] = data;
            OP_DOF_VAL:  if (comp < NCOMP) dof_val[row*NCOMP+comp] = data;
            OP_DOF_DET:  dof_det[row] = data;
            OP_JACOBIAN: pt_jac[row] = data;
            OP_EVALUATE: predict_element();
            default: ;
        endcase
    endtask

    task automatic send_request(logic [2:0] op, logic [2:0] row, logic [2:0] col,
                                logic [1:0] comp, logic [31:0] data);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {data, comp, col, row};
        do @(posedge aclk); while (!s_tready);
        apply_request(op, row, col, comp, data);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NUM_DOFS:   r_dofs = val;
            CFG_NUM_POINTS: r_points = val;
            CFG_NUM_COMP:   r_comps = val[1:0];
            CFG_EVAL_MASK:  r_mask = val;
            CFG_INTEGRAL:   r_integ = val[0];
            CFG_ORDER:      r_order = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_config(logic [3:0] nd, logic [3:0] nq, logic [1:0] nc,
                              logic [3:0] mask, logic integ, logic order);
        drain_results();
        write_reg(CFG_NUM_DOFS, nd);
        write_reg(CFG_NUM_POINTS, nq);
        write_reg(CFG_NUM_COMP, {2'b00, nc});
        write_reg(CFG_EVAL_MASK, mask);
        write_reg(CFG_INTEGRAL, {3'b000, integ});
        write_reg(CFG_ORDER, {3'b000, order});
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3, 4: return $urandom;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic fill_stores();
        for (int q = 0; q < NPT; q++) begin
            for (int d = 0; d < NDOF; d++) begin
                send_request(OP_BASIS, 3'(q), 3'(d), 2'($urandom), pick_word());
                send_request(OP_GRADIENT, 3'(q), 3'(d), 2'($urandom), pick_word());
            end
            send_request(OP_JACOBIAN, 3'(q), 3'($urandom), 2'($urandom),
                         $urandom_range(32'h0003_0000) + 1);
        end
        for (int d = 0; d < NDOF; d++) begin
            for (int c = 0; c < NCOMP; c++)
                send_request(OP_DOF_VAL, 3'(d), 3'($urandom), 2'(c), pick_word());
            send_request(OP_DOF_DET, 3'(d), 3'($urandom), 2'($urandom),
                         $urandom_range(32'h0003_0000) + 1);
        end
    endtask

    task automatic test_directed();
        set_config(4'd2, 4'd1, 2'd1, 4'hF, 1'b0, 1'b0);
        send_request(OP_BASIS, 0, 0, 0, 32'h7fff_ffff);
        send_request(OP_BASIS, 0, 1, 0, 32'h8000_0000);
        send_request(OP_GRADIENT, 0, 0, 0, 32'h8000_0000);
        send_request(OP_GRADIENT, 0, 1, 0, 32'h8000_0000);
        send_request(OP_DOF_VAL, 0, 0, 0, 32'h7fff_ffff);
        send_request(OP_DOF_VAL, 1, 0, 0, 32'h8000_0000);
        send_request(OP_JACOBIAN, 0, 0, 0, 32'h0000_0000);
        send_request(OP_EVALUATE, 0, 0, 0, 32'h0);
        send_request(3'd6, 3'd7, 3'd7, 2'd3, 32'hffff_ffff);
        send_request(3'd7, 0, 0, 0, 32'h0);
        send_request(OP_DOF_VAL, 7, 0, 2'd3, 32'h1234_5678);
        set_config(4'd2, 4'd2, 2'd1, 4'hF, 1'b1, 1'b1);
        send_request(OP_DOF_DET, 1, 0, 0, 32'h0000_0000);
        send_request(OP_JACOBIAN, 1, 0, 0, 32'h0000_8000);
        send_request(OP_EVALUATE, 0, 0, 0, 32'h0);
        send_request(OP_DOF_DET, 1, 0, 0, 32'hffff_0000);
        set_config(4'd0, 4'd15, 2'd3, 4'h8, 1'b0, 1'b1);
        send_request(OP_EVALUATE, 0, 0, 0, 32'h0);
        set_config(4'd15, 4'd0, 2'd0, 4'h0, 1'b0, 1'b0);
        send_request(OP_EVALUATE, 0, 0, 0, 32'h0);
        set_config(4'd8, 4'd8, 2'd2, 4'h7, 1'b1, 1'b0);
        send_request(OP_EVALUATE, 0, 0, 0, 32'h0);
    endtask

    task automatic random_config();
        set_config(4'($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(1, 4)),
                   4'($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(1, 3)),
                   2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom),
                   1'($urandom));
    endtask

    task automatic test_random(int items);
        int pick;
        for (int n = 0; n < items; n++) begin
            if (n % 25 == 0) random_config();
            pick = $urandom_range(99);
            if (pick < 22)
                send_request(OP_EVALUATE, 3'($urandom), 3'($urandom), 2'($urandom), $urandom);
            else if (pick < 27)
                send_request(3'($urandom_range(6, 7)), 3'($urandom), 3'($urandom),
                             2'($urandom), $urandom);
            else
                send_request(3'($urandom_range(4)), 3'($urandom), 3'($urandom),
                             2'($urandom), pick_word());
        end
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %p actual %p", what, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.point_index = m_tdata[2:0];
            got.component = m_tdata[4:3];
            got.value = m_tdata[36:5];
            got.derivative = m_tdata[68:37];
            got.determinant = m_tdata[100:69];
            got.div_fault = m_tuser[0];
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                want = '0;
                report_mismatch("unexpected result");
            end else begin
                want = pending_results.pop_front();
                if (got.point_index !== want.point_index) report_mismatch("point_index");
                else if (got.component !== want.component) report_mismatch("component");
                else if (got.value !== want.value) report_mismatch("value");
                else if (got.derivative !== want.derivative) report_mismatch("derivative");
                else if (got.determinant !== want.determinant) report_mismatch("determinant");
                else if (got.div_fault !== want.div_fault) report_mismatch("div_fault");
                else if (got.last !== want.last) report_mismatch("last");
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    initial begin
        for (int i = 0; i < NPT*NDOF; i++) begin
            basis_tab[i] = '0;
            grad_tab[i] = '0;
        end
        for (int i = 0; i < NDOF*NCOMP; i++) dof_val[i] = '0;
        for (int i = 0; i < NDOF; i++) dof_det[i] = '0;
        for (int i = 0; i < NPT; i++) pt_jac[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle = 36;
        snk_idle = 45;
        fill_stores();
        test_directed();
        test_random(12);
        src_idle = 45;
        snk_idle = 36;
        test_random(12);
        src_idle = 0;
        snk_idle = 0;
        test_random(12);
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS quadrature_point_interpolator");
        end else begin
            $display("FAIL quadrature_point_interpolator");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL quadrature_point_interpolator");
        $finish;
    end

endmodule
